// ===== rtl/core/pcx_rle_pkg.sv =====
// ----------------------------------------------------------------------------
// PCX RLE decoder package
// Shared types, register map and stream constants for the scanline decoder.
// ----------------------------------------------------------------------------
package pcx_rle_pkg;

  localparam logic [1:0] RUN_MARK   = 2'b11;
  localparam logic [5:0] COUNT_MASK = 6'h3F;

  localparam int unsigned ADDR_W = 4;
  localparam int unsigned DATA_W = 32;

  localparam logic [1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [1:0] REG_LINE_BYTES   = 2'd1;
  localparam logic [1:0] REG_PLANE_COUNT  = 2'd2;
  localparam logic [1:0] REG_IMAGE_HEIGHT = 2'd3;

  typedef enum logic [1:0] {
    S_IDLE,
    S_ITER,
    S_FLUSH
  } state_t;

  typedef struct packed {
    logic accept;
    logic step;
    logic flush;
  } cmd_t;

  typedef struct packed {
    logic finished;
    logic awaiting;
    logic is_run;
    logic pend_zero;
    logic emit;
    logic done;
    logic step_ok;
    logic hold_valid;
    logic out_free;
  } stat_t;

endpackage

// ===== rtl/core/pcx_rle_ctrl.sv =====
// ----------------------------------------------------------------------------
// PCX RLE decoder controller
// Sequences byte acceptance, per-pixel iteration and the final pixel flush.
// ----------------------------------------------------------------------------
module pcx_rle_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                data_valid,
  input  pcx_rle_pkg::stat_t  stat,
  output logic                data_ready,
  output pcx_rle_pkg::cmd_t   cmd
);

  pcx_rle_pkg::state_t state;
  pcx_rle_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pcx_rle_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    data_ready = 1'b0;
    case (state)
      pcx_rle_pkg::S_IDLE: begin
        data_ready = 1'b1;
        if (data_valid) begin
          cmd.accept = 1'b1;
          if (!stat.finished &&
              (stat.awaiting ? !stat.pend_zero : !stat.is_run)) begin
            state_next = pcx_rle_pkg::S_ITER;
          end
        end
      end
      pcx_rle_pkg::S_ITER: begin
        if (stat.step_ok) begin
          cmd.step = 1'b1;
          if (stat.done) begin
            state_next = (stat.hold_valid || stat.emit) ?
                         pcx_rle_pkg::S_FLUSH : pcx_rle_pkg::S_IDLE;
          end
        end
      end
      pcx_rle_pkg::S_FLUSH: begin
        if (stat.out_free) begin
          cmd.flush  = 1'b1;
          state_next = pcx_rle_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = pcx_rle_pkg::S_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/core/pcx_rle_dp.sv =====
// ----------------------------------------------------------------------------
// PCX RLE decoder datapath
// Run state, position counters, one-pixel hold stage and output register.
// ----------------------------------------------------------------------------
module pcx_rle_dp (
  input  logic               clk,
  input  logic               rst,
  input  pcx_rle_pkg::cmd_t  cmd,
  input  logic [7:0]         data_byte,
  input  logic [15:0]        image_width,
  input  logic [15:0]        line_bytes,
  input  logic [1:0]         plane_count,
  input  logic [15:0]        image_height,
  input  logic               pixel_ready,
  output pcx_rle_pkg::stat_t stat,
  output logic               pixel_valid,
  output logic [7:0]         pixel_value,
  output logic [1:0]         plane_index,
  output logic [15:0]        column,
  output logic [15:0]        line_number,
  output logic               last_of_input
);

  logic        awaiting;
  logic [5:0]  pend_cnt;
  logic [5:0]  remaining;
  logic [7:0]  value;
  logic [15:0] pos;
  logic [1:0]  plane;
  logic [15:0] row;
  logic        finished;

  logic        hold_valid;
  logic [7:0]  hold_value;
  logic [1:0]  hold_plane;
  logic [15:0] hold_col;
  logic [15:0] hold_row;

  logic [15:0] pos_inc;
  logic [1:0]  plane_inc;
  logic [15:0] row_inc;
  logic        emit;
  logic        plane_end;
  logic        line_end;
  logic        done;
  logic        out_free;
  logic        push_mid;

  assign pos_inc   = pos + 16'd1;
  assign plane_inc = plane + 2'd1;
  assign row_inc   = row + 16'd1;
  assign emit      = pos < image_width;
  assign plane_end = pos_inc >= line_bytes;
  assign line_end  = plane_end && (plane_inc >= plane_count);
  assign done      = line_end || (remaining == 6'd1);
  assign out_free  = !pixel_valid || pixel_ready;
  assign push_mid  = cmd.step && emit && hold_valid;

  assign stat.finished   = finished;
  assign stat.awaiting   = awaiting;
  assign stat.is_run     = data_byte[7:6] == pcx_rle_pkg::RUN_MARK;
  assign stat.pend_zero  = pend_cnt == 6'd0;
  assign stat.emit       = emit;
  assign stat.done       = done;
  assign stat.step_ok    = !(emit && hold_valid) || out_free;
  assign stat.hold_valid = hold_valid;
  assign stat.out_free   = out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      awaiting <= 1'b0;
      pend_cnt <= '0;
      pos      <= '0;
      plane    <= '0;
      row      <= '0;
      finished <= 1'b0;
    end else if (cmd.accept && !finished) begin
      if (awaiting) begin
        awaiting <= 1'b0;
        pend_cnt <= '0;
      end else if (stat.is_run) begin
        awaiting <= 1'b1;
        pend_cnt <= data_byte[5:0] & pcx_rle_pkg::COUNT_MASK;
      end
    end else if (cmd.step) begin
      if (plane_end) begin
        pos <= '0;
        if (plane_inc >= plane_count) begin
          plane <= '0;
          row   <= row_inc;
          if (row_inc >= image_height) begin
            finished <= 1'b1;
          end
        end else begin
          plane <= plane_inc;
        end
      end else begin
        pos <= pos_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      value     <= data_byte;
      remaining <= awaiting ? pend_cnt : 6'd1;
    end else if (cmd.step) begin
      remaining <= remaining - 6'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (cmd.step && emit) begin
      hold_valid <= 1'b1;
    end else if (cmd.flush) begin
      hold_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.step && emit) begin
      hold_value <= value;
      hold_plane <= plane;
      hold_col   <= pos;
      hold_row   <= row;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_valid <= 1'b0;
    end else if (push_mid || cmd.flush) begin
      pixel_valid <= 1'b1;
    end else if (pixel_ready) begin
      pixel_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push_mid || cmd.flush) begin
      pixel_value   <= hold_value;
      plane_index   <= hold_plane;
      column        <= hold_col;
      line_number   <= hold_row;
      last_of_input <= cmd.flush;
    end
  end

endmodule

// ===== rtl/core/pcx_rle_scanline_decoder_unit.sv =====
// ----------------------------------------------------------------------------
// PCX RLE scanline decoder
// Path: a kept literal byte is stored as the run value, then moves via the one-pixel
//   hold stage to the output register. Run markers, zero-length run values and
//   bytes after the image skip the decode loop, which steps one pixel per cycle and
//   stalls on output; no new byte is taken until a byte's pixels and any flush are done.
// Reset: synchronous, active high; registers return to 1, stream state clears.
// ----------------------------------------------------------------------------
module pcx_rle_scanline_decoder_unit (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [pcx_rle_pkg::ADDR_W-1:0]    paddr,
  input  logic [pcx_rle_pkg::DATA_W-1:0]    pwdata,
  output logic [pcx_rle_pkg::DATA_W-1:0]    prdata,
  output logic                              pready,
  input  logic                              data_valid,
  output logic                              data_ready,
  input  logic [7:0]                        data_byte,
  output logic                              pixel_valid,
  input  logic                              pixel_ready,
  output logic [7:0]                        pixel_value,
  output logic [1:0]                        plane_index,
  output logic [15:0]                       column,
  output logic [15:0]                       line_number,
  output logic                              last_of_input
);

  logic [15:0] image_width;
  logic [15:0] line_bytes;
  logic [1:0]  plane_count;
  logic [15:0] image_height;
  logic [1:0]  reg_index;
  logic        reg_write;

  pcx_rle_pkg::cmd_t  cmd;
  pcx_rle_pkg::stat_t stat;

  assign pready    = 1'b1;
  assign reg_index = paddr[3:2];
  assign reg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= 16'd1;
      line_bytes   <= 16'd1;
      plane_count  <= 2'd1;
      image_height <= 16'd1;
    end else if (reg_write) begin
      case (reg_index)
        pcx_rle_pkg::REG_IMAGE_WIDTH:  image_width <= pwdata[15:0];
        pcx_rle_pkg::REG_LINE_BYTES:   line_bytes  <= pwdata[15:0];
        pcx_rle_pkg::REG_PLANE_COUNT:
          plane_count <= (pwdata[1:0] == 2'd0) ? 2'd1 : pwdata[1:0];
        pcx_rle_pkg::REG_IMAGE_HEIGHT:
          image_height <= (pwdata[15:0] == 16'd0) ? 16'd1 : pwdata[15:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (reg_index)
      pcx_rle_pkg::REG_IMAGE_WIDTH:  prdata[15:0] = image_width;
      pcx_rle_pkg::REG_LINE_BYTES:   prdata[15:0] = line_bytes;
      pcx_rle_pkg::REG_PLANE_COUNT:  prdata[1:0]  = plane_count;
      pcx_rle_pkg::REG_IMAGE_HEIGHT: prdata[15:0] = image_height;
      default:                       prdata       = '0;
    endcase
  end

  pcx_rle_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .data_valid (data_valid),
    .stat       (stat),
    .data_ready (data_ready),
    .cmd        (cmd)
  );

  pcx_rle_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .data_byte     (data_byte),
    .image_width   (image_width),
    .line_bytes    (line_bytes),
    .plane_count   (plane_count),
    .image_height  (image_height),
    .pixel_ready   (pixel_ready),
    .stat          (stat),
    .pixel_valid   (pixel_valid),
    .pixel_value   (pixel_value),
    .plane_index   (plane_index),
    .column        (column),
    .line_number   (line_number),
    .last_of_input (last_of_input)
  );

`ifndef NO_ASSERTIONS
  a_accept_cmd: assert property (@(posedge clk) disable iff (rst)
    (data_valid && data_ready) |-> (cmd.accept && !cmd.step && !cmd.flush))
    else $error("transaction accepted without accept command");

  a_flush_hold: assert property (@(posedge clk) disable iff (rst)
    cmd.flush |-> (stat.hold_valid && stat.out_free))
    else $error("flush without a held pixel or free output");

  a_flush_last: assert property (@(posedge clk) disable iff (rst)
    cmd.flush |=> (pixel_valid && last_of_input))
    else $error("flushed pixel not marked last");

  a_finished_sticky: assert property (@(posedge clk) disable iff (rst)
    stat.finished |=> stat.finished)
    else $error("image finished flag cleared without reset");
`endif

endmodule

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// PCX RLE scanline decoder testbench
// Feeds compressed PCX byte streams through the valid/ready input channel and
// checks each decoded pixel against an in-bench decoder that tracks run state,
// plane, column and row. Geometry is reprogrammed over APB between idle phases,
// both channels throttle at random, and the run ends with trailing bytes
// after the last scanline.
// ----------------------------------------------------------------------------
module testbench;

  localparam int SETTLE      = 80;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic [7:0]  value;
    logic [1:0]  plane;
    logic [15:0] col;
    logic [15:0] row;
    logic        last_in;
  } pixel_t;

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           psel = 1'b0;
  logic                           penable = 1'b0;
  logic                           pwrite = 1'b0;
  logic [pcx_rle_pkg::ADDR_W-1:0] paddr = '0;
  logic [pcx_rle_pkg::DATA_W-1:0] pwdata = '0;
  logic [pcx_rle_pkg::DATA_W-1:0] prdata;
  logic                           pready;
  logic                           data_valid = 1'b0;
  logic                           data_ready;
  logic [7:0]                     data_byte = 8'h00;
  logic                           pixel_valid;
  logic                           pixel_ready = 1'b0;
  logic [7:0]                     pixel_value;
  logic [1:0]                     plane_index;
  logic [15:0]                    column;
  logic [15:0]                    line_number;
  logic                           last_of_input;

  logic [7:0] stream_bytes[$];
  pixel_t     pending_pixels[$];
  int         bytes_pushed = 0;
  int         bytes_taken = 0;
  int         pixels_checked = 0;
  int         geometries = 0;
  int         mismatches = 0;
  int         cycle_count = 0;
  bit         gaps_on = 1'b1;

  logic [15:0] cfg_width, cfg_line_bytes, cfg_height;
  logic [1:0]  cfg_planes;
  logic        st_await, st_done;
  logic [5:0]  st_count;
  logic [15:0] st_pos, st_row;
  logic [1:0]  st_plane;

  pcx_rle_scanline_decoder_unit u_dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .data_valid(data_valid), .data_ready(data_ready), .data_byte(data_byte),
    .pixel_valid(pixel_valid), .pixel_ready(pixel_ready),
    .pixel_value(pixel_value), .plane_index(plane_index), .column(column),
    .line_number(line_number), .last_of_input(last_of_input)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("pcx_rle_scanline_decoder_unit test failed");
      $finish;
    end
  end

  task automatic note_mismatch(input string msg);
    mismatches++;
    $display("[%0d] mismatch: %s", cycle_count, msg);
  endtask

  function automatic void decode_byte(input logic [7:0] b);
    int unsigned reps;
    int          first;
    bit          line_end;
    pixel_t      px;
    if (st_done) return;
    if (st_await) begin
      st_await = 1'b0;
      reps = st_count;
      st_count = '0;
    end else if (b[7:6] == pcx_rle_pkg::RUN_MARK) begin
      st_await = 1'b1;
      st_count = b[5:0] & pcx_rle_pkg::COUNT_MASK;
      return;
    end else begin
      reps = 1;
    end
    first = pending_pixels.size();
    for (int i = 0; i < reps; i++) begin
      line_end = 1'b0;
      if (st_pos < cfg_width) begin
        px = '{value: b, plane: st_plane, col: st_pos, row: st_row, last_in: 1'b0};
        pending_pixels.push_back(px);
      end
      st_pos = st_pos + 16'd1;
      if (st_pos >= cfg_line_bytes) begin
        st_pos = '0;
        st_plane = st_plane + 2'd1;
        if (st_plane >= cfg_planes) begin
          st_plane = '0;
          line_end = 1'b1;
          st_row = st_row + 16'd1;
          if (st_row >= cfg_height) st_done = 1'b1;
        end
      end
      if (line_end) break;
    end
    if (pending_pixels.size() > first) begin
      px = pending_pixels.pop_back();
      px.last_in = 1'b1;
      pending_pixels.push_back(px);
    end
  endfunction

  function automatic void apply_register(input logic [1:0] idx,
                                         input logic [31:0] val);
    case (idx)
      pcx_rle_pkg::REG_IMAGE_WIDTH:  cfg_width = val[15:0];
      pcx_rle_pkg::REG_LINE_BYTES:   cfg_line_bytes = val[15:0];
      pcx_rle_pkg::REG_PLANE_COUNT:
        cfg_planes = (val[1:0] == 2'd0) ? 2'd1 : val[1:0];
      pcx_rle_pkg::REG_IMAGE_HEIGHT:
        cfg_height = (val[15:0] == 16'd0) ? 16'd1 : val[15:0];
      default: ;
    endcase
  endfunction

  // transaction check
  always @(posedge clk) begin
    if (rst) begin
      pixel_ready <= 1'b0;
    end else begin
      if (pixel_valid && pixel_ready) begin
        if (pending_pixels.size() == 0) begin
          note_mismatch($sformatf("unexpected pixel val=%h plane=%0d col=%0d row=%0d",
                                  pixel_value, plane_index, column, line_number));
        end else begin
          pixel_t want;
          want = pending_pixels.pop_front();
          pixels_checked++;
          if (pixel_value !== want.value || plane_index !== want.plane ||
              column !== want.col || line_number !== want.row ||
              last_of_input !== want.last_in) begin
            note_mismatch($sformatf(
              {"got val=%h pl=%0d col=%0d row=%0d last=%b ",
               "exp val=%h pl=%0d col=%0d row=%0d last=%b"},
              pixel_value, plane_index, column, line_number, last_of_input,
              want.value, want.plane, want.col, want.row, want.last_in));
          end
        end
      end
      pixel_ready <= !gaps_on || ($urandom_range(99) >= 12);
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      data_valid <= 1'b0;
    end else begin
      if (data_valid && data_ready) begin
        decode_byte(data_byte);
        bytes_taken++;
      end
      if (!data_valid || data_ready) begin
        if (stream_bytes.size() != 0 && (!gaps_on || $urandom_range(99) >= 12)) begin
          data_valid <= 1'b1;
          data_byte <= stream_bytes.pop_front();
        end else begin
          data_valid <= 1'b0;
        end
      end
    end
  end

  task automatic push_byte(input logic [7:0] b);
    stream_bytes.push_back(b);
    bytes_pushed++;
  endtask

  task automatic push_stream(input int n);
    int r;
    int i;
    i = 0;
    while (i < n) begin
      r = $urandom_range(99);
      if (r < 65) begin
        push_byte(8'($urandom_range(8'hBF, 0)));
        i++;
      end else begin
        if ($urandom_range(99) < 75) begin
          push_byte({pcx_rle_pkg::RUN_MARK, 6'($urandom_range(6, 0))});
        end else begin
          push_byte({pcx_rle_pkg::RUN_MARK, 6'($urandom_range(63, 0))});
        end
        push_byte(8'($urandom_range(255, 0)));
        i += 2;
      end
    end
  endtask

  task automatic drain();
    @(negedge clk);
    while (!(bytes_taken == bytes_pushed && pending_pixels.size() == 0)) @(negedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic apb_write(input logic [1:0] idx, input logic [31:0] val);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    apply_register(idx, val);
  endtask

  task automatic set_geometry(input logic [15:0] w, input logic [15:0] lb,
                              input logic [1:0] planes, input logic [15:0] h);
    apb_write(pcx_rle_pkg::REG_IMAGE_WIDTH, {16'd0, w});
    apb_write(pcx_rle_pkg::REG_LINE_BYTES, {16'd0, lb});
    apb_write(pcx_rle_pkg::REG_PLANE_COUNT, {30'd0, planes});
    apb_write(pcx_rle_pkg::REG_IMAGE_HEIGHT, {16'd0, h});
    geometries++;
  endtask

  task automatic random_geometry();
    logic [15:0] w;
    w = 16'($urandom_range(12, 1));
    set_geometry(w, w + 16'($urandom_range(3, 0)), 2'($urandom_range(3, 1)), 16'hFFFF);
  endtask

  initial begin
    logic [7:0] directed[$];
    cfg_width = 16'd1;
    cfg_line_bytes = 16'd1;
    cfg_planes = 2'd1;
    cfg_height = 16'd1;
    st_await = 1'b0;
    st_count = '0;
    st_pos = '0;
    st_plane = '0;
    st_row = '0;
    st_done = 1'b0;

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // literals, zero run, runs across plane and line ends, value bytes with run bits
    set_geometry(16'd4, 16'd6, 2'd3, 16'hFFFF);
    directed = '{8'h00, 8'hBF, 8'h7F, 8'h40, 8'hC0, 8'h55, 8'hC3, 8'hFF,
                 8'hFF, 8'hC0, 8'hC1, 8'h00, 8'h80, 8'h3F, 8'hC8, 8'hAA};
    foreach (directed[k]) push_byte(directed[k]);
    drain();

    random_geometry();
    gaps_on = 1'b0;
    push_stream(120);
    drain();
    gaps_on = 1'b1;

    set_geometry(16'hFFFF, 16'd3, 2'd2, 16'hFFFF);
    push_stream(40);
    drain();

    set_geometry(16'd5, 16'd0, 2'd0, 16'hFFFF);
    push_stream(30);
    drain();

    set_geometry(16'd0, 16'd4, 2'd3, 16'hFFFF);
    push_stream(20);
    drain();

    set_geometry(16'hFFFF, 16'hFFFF, 2'd3, 16'hFFFF);
    push_stream(30);
    drain();

    random_geometry();
    push_stream(60);
    drain();
    push_stream(60);
    drain();

    // finish the image, then trailing bytes must be swallowed
    set_geometry(16'd3, 16'd3, 2'd1, 16'd0);
    repeat (8) push_byte(8'($urandom_range(8'hBF, 0)));
    push_stream(20);
    drain();

    if (pending_pixels.size() != 0)
      note_mismatch($sformatf("%0d pixels never arrived", pending_pixels.size()));
    $display("covered %0d stream bytes over %0d geometries,", bytes_taken, geometries);
    $display("%0d pixels checked, %0d mismatches", pixels_checked, mismatches);
    if (mismatches == 0) begin
      $display("pcx_rle_scanline_decoder_unit test passed");
    end else begin
      $display("pcx_rle_scanline_decoder_unit test failed");
    end
    $finish;
  end

endmodule
